@@ rtl/dual_modulus_rolling_hash_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the dual modulus rolling hash
// Each macro assumes clk and rst_n are visible at the place of use.
// ----------------------------------------------------------------------------
`ifndef DUAL_MODULUS_ROLLING_HASH_ASSERT_SVH
`define DUAL_MODULUS_ROLLING_HASH_ASSERT_SVH
`ifndef SYNTHESIS
`define DMRH_ASSERT_IMPL(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define DMRH_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define DMRH_ASSERT_IMPL(label, cond, prop)
`define DMRH_ASSERT_NEXT(label, cond, prop)
`endif
`endif

@@ rtl/dmrh_pkg.sv @@
// ----------------------------------------------------------------------------
// dmrh_pkg
// Types, constants and helpers shared by the rolling hash modules.
// ----------------------------------------------------------------------------
package dmrh_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int LEN_W     = 11;
    localparam int OUT_LEN_W = 12;
    localparam int HASH_W    = 31;
    localparam int SYM_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = 2 * HASH_W;
    localparam int VAL_W     = PROD_W + 1;
    localparam int STEP_W    = $clog2(VAL_W);
    localparam int TBL_DEPTH = MAX_LEN + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_A = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_B = 2'd2;

    typedef enum logic [1:0] {
        KIND_APPEND = 2'd0,
        KIND_QUERY  = 2'd1,
        KIND_CONCAT = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic               static_err;
        logic [SYM_W-1:0]   symbol;
        logic [LEN_W-1:0]   left;
        logic [LEN_W-1:0]   right;
        logic [HASH_W-1:0]  first_hash_a;
        logic [HASH_W-1:0]  first_hash_b;
        logic [LEN_W-1:0]   first_len;
        logic [HASH_W-1:0]  second_hash_a;
        logic [HASH_W-1:0]  second_hash_b;
        logic [LEN_W-1:0]   second_len;
    } cmd_t;

    typedef enum logic [1:0] {
        MM_IDLE,
        MM_MUL,
        MM_RED
    } mm_state_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_CHECK,
        BK_EXTEND,
        BK_EXT_WAIT,
        BK_Q_RD1,
        BK_Q_RD2,
        BK_C_RD,
        BK_APP_RD,
        BK_CALC
    } back_state_t;

    function automatic logic [HASH_W-1:0] eff_mod(input logic [HASH_W-1:0] m);
        return (m < HASH_W'(2)) ? HASH_W'(2) : m;
    endfunction

endpackage

@@ rtl/dual_modulus_rolling_hash.sv @@
// ----------------------------------------------------------------------------
// dual_modulus_rolling_hash
// Polynomial rolling hash of one stored string under two moduli at once.
//
// Channel   Direction  Handshake            Payload
// command   in         start / busy         kind, symbol, left, right, operands
// result    out        done (one cycle)     hash_a, hash_b, length, error
// config    in         cfg_write            cfg_index, cfg_data
//
// An append runs one modular multiply; a query or concatenation runs one
// plus one more first for each missing power table entry past entry zero.
// Their run time is set by the modular multiply units, which reduce one bit of
// the 63-bit sum per cycle. Errors and clears give their result word
// without starting a modular multiply.
// Reset needs no clearing pass: entry zero of the prefix tables reads as zero.
// Two command words can wait in the queue; the result side never stalls.
// ----------------------------------------------------------------------------
`include "dual_modulus_rolling_hash_assert.svh"

module dual_modulus_rolling_hash
    import dmrh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           kind,
    input  logic [SYM_W-1:0]     symbol,
    input  logic [LEN_W-1:0]     left,
    input  logic [LEN_W-1:0]     right,
    input  logic [HASH_W-1:0]    first_hash_a,
    input  logic [HASH_W-1:0]    first_hash_b,
    input  logic [LEN_W-1:0]     first_len,
    input  logic [HASH_W-1:0]    second_hash_a,
    input  logic [HASH_W-1:0]    second_hash_b,
    input  logic [LEN_W-1:0]     second_len,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [HASH_W-1:0]    cfg_data,
    output logic                 done,
    output logic [HASH_W-1:0]    hash_a,
    output logic [HASH_W-1:0]    hash_b,
    output logic [OUT_LEN_W-1:0] length,
    output logic                 error
);

    logic [HASH_W-1:0] base_reg;
    logic [HASH_W-1:0] mod_a_reg;
    logic [HASH_W-1:0] mod_b_reg;
    logic [HASH_W-1:0] mod_a_eff;
    logic [HASH_W-1:0] mod_b_eff;
    logic              cfg_hit;
    logic              q_valid;
    logic              q_pop;
    cmd_t              q_head;

    assign cfg_hit = cfg_write && (cfg_index == CFG_BASE || cfg_index == CFG_MOD_A ||
                                   cfg_index == CFG_MOD_B);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= HASH_W'(1007);
            mod_a_reg <= HASH_W'(1000000007);
            mod_b_reg <= HASH_W'(998244353);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_BASE:  base_reg  <= cfg_data;
                CFG_MOD_A: mod_a_reg <= cfg_data;
                CFG_MOD_B: mod_b_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    assign mod_a_eff = eff_mod(mod_a_reg);
    assign mod_b_eff = eff_mod(mod_b_reg);

    dmrh_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .symbol        (symbol),
        .left          (left),
        .right         (right),
        .first_hash_a  (first_hash_a),
        .first_hash_b  (first_hash_b),
        .first_len     (first_len),
        .second_hash_a (second_hash_a),
        .second_hash_b (second_hash_b),
        .second_len    (second_len),
        .busy          (busy),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop)
    );

    dmrh_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .cfg_base     (base_reg),
        .mod_a_eff    (mod_a_eff),
        .mod_b_eff    (mod_b_eff),
        .powers_clear (cfg_hit),
        .done         (done),
        .hash_a       (hash_a),
        .hash_b       (hash_b),
        .length       (length),
        .error        (error)
    );

    `DMRH_ASSERT_IMPL(a_err_zero, done && error, hash_a == '0 && hash_b == '0 && length == '0)
    `DMRH_ASSERT_IMPL(a_hash_reduced, done && !error, hash_a < mod_a_eff && hash_b < mod_b_eff)
    `DMRH_ASSERT_NEXT(a_done_gap, done, !done)

endmodule

@@ rtl/dmrh_ram.sv @@
// ----------------------------------------------------------------------------
// dmrh_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module dmrh_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/dmrh_front.sv @@
// ----------------------------------------------------------------------------
// dmrh_front
// Accepts command words, flags range errors that need no string state,
// and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module dmrh_front
    import dmrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [SYM_W-1:0]  symbol,
    input  logic [LEN_W-1:0]  left,
    input  logic [LEN_W-1:0]  right,
    input  logic [HASH_W-1:0] first_hash_a,
    input  logic [HASH_W-1:0] first_hash_b,
    input  logic [LEN_W-1:0]  first_len,
    input  logic [HASH_W-1:0] second_hash_a,
    input  logic [HASH_W-1:0] second_hash_b,
    input  logic [LEN_W-1:0]  second_len,
    output logic              busy,
    output logic              q_valid,
    output cmd_t              q_head,
    input  logic              q_pop
);

    cmd_t       q_mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       accept;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.kind          = kind_t'(kind);
        cmd_in.symbol        = symbol;
        cmd_in.left          = left;
        cmd_in.right         = right;
        cmd_in.first_hash_a  = first_hash_a;
        cmd_in.first_hash_b  = first_hash_b;
        cmd_in.first_len     = first_len;
        cmd_in.second_hash_a = second_hash_a;
        cmd_in.second_hash_b = second_hash_b;
        cmd_in.second_len    = second_len;
        unique case (kind_t'(kind))
            KIND_QUERY:
            begin
                cmd_in.static_err = (left > right) || (right > LEN_W'(MAX_LEN));
            end
            KIND_CONCAT:
            begin
                cmd_in.static_err = (first_len > LEN_W'(MAX_LEN)) ||
                                    (second_len > LEN_W'(MAX_LEN));
            end
            default:
            begin
                cmd_in.static_err = 1'b0;
            end
        endcase
    end

    assign busy    = (count_reg == 2'd2);
    assign accept  = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_head  = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = accept ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, accept} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ rtl/dmrh_mulmod.sv @@
// ----------------------------------------------------------------------------
// dmrh_mulmod
// Computes (op_a * op_b + op_c) mod modulus: one multiply, one add, then a
// restoring remainder that takes one bit of the sum per cycle.
// ----------------------------------------------------------------------------
module dmrh_mulmod
    import dmrh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [HASH_W-1:0] op_a,
    input  logic [HASH_W-1:0] op_b,
    input  logic [HASH_W-1:0] op_c,
    input  logic [HASH_W-1:0] modulus,
    output logic              done,
    output logic [HASH_W-1:0] result
);

    mm_state_t          state_reg, state_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [PROD_W-1:0]  prod_reg;
    logic [HASH_W-1:0]  c_reg;
    logic [HASH_W-1:0]  m_reg;
    logic [VAL_W-1:0]   val_reg;
    logic [HASH_W-1:0]  rem_reg;
    logic [HASH_W:0]    trial;
    logic [HASH_W:0]    diff;

    assign trial = {rem_reg, val_reg[VAL_W-1]};
    assign diff  = trial - {1'b0, m_reg};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MM_IDLE:
            begin
                if (start)
                begin
                    state_next = MM_MUL;
                end
            end
            MM_MUL:
            begin
                state_next = MM_RED;
                cnt_next   = '0;
            end
            MM_RED:
            begin
                cnt_next = cnt_reg + STEP_W'(1);
                if (cnt_reg == STEP_W'(VAL_W - 1))
                begin
                    state_next = MM_IDLE;
                    done_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = MM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MM_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == MM_IDLE && start)
        begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
            c_reg    <= op_c;
            m_reg    <= modulus;
        end
        else if (state_reg == MM_MUL)
        begin
            val_reg <= {1'b0, prod_reg} + VAL_W'(c_reg);
            rem_reg <= '0;
        end
        else if (state_reg == MM_RED)
        begin
            val_reg <= {val_reg[VAL_W-2:0], 1'b0};
            rem_reg <= (trial >= {1'b0, m_reg}) ? diff[HASH_W-1:0] : trial[HASH_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

endmodule

@@ rtl/dmrh_back.sv @@
// ----------------------------------------------------------------------------
// dmrh_back
// Executes queued command words: keeps the prefix hash and power tables,
// extends the power table on demand and forms each result word.
// ----------------------------------------------------------------------------
module dmrh_back
    import dmrh_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  cmd_t                 q_head,
    output logic                 q_pop,
    input  logic [HASH_W-1:0]    cfg_base,
    input  logic [HASH_W-1:0]    mod_a_eff,
    input  logic [HASH_W-1:0]    mod_b_eff,
    input  logic                 powers_clear,
    output logic                 done,
    output logic [HASH_W-1:0]    hash_a,
    output logic [HASH_W-1:0]    hash_b,
    output logic [OUT_LEN_W-1:0] length,
    output logic                 error
);

    back_state_t           state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      pv_reg, pv_next;
    logic [LEN_W-1:0]      d_reg, d_next;
    logic [HASH_W-1:0]     last_a_reg, last_a_next;
    logic [HASH_W-1:0]     last_b_reg, last_b_next;
    logic [HASH_W-1:0]     p_a_reg, p_a_next;
    logic [HASH_W-1:0]     p_b_reg, p_b_next;
    logic [HASH_W-1:0]     hl_a_reg, hl_a_next;
    logic [HASH_W-1:0]     hl_b_reg, hl_b_next;
    logic                  pre_zero_reg;
    logic                  done_reg, done_next;
    logic [HASH_W-1:0]     hash_a_reg, hash_a_next;
    logic [HASH_W-1:0]     hash_b_reg, hash_b_next;
    logic [OUT_LEN_W-1:0]  length_reg, length_next;
    logic                  error_reg, error_next;

    logic                  pre_rd_en, pre_wr_en;
    logic [LEN_W-1:0]      pre_rd_addr, pre_wr_addr;
    logic [HASH_W-1:0]     pre_a_q, pre_b_q, pre_a_val, pre_b_val;
    logic                  pow_rd_en, pow_wr_en;
    logic [LEN_W-1:0]      pow_rd_addr, pow_wr_addr;
    logic [HASH_W-1:0]     pow_wr_a, pow_wr_b, pow_a_q, pow_b_q;

    logic                  mm_start, mm_done_a, mm_done_b, mm_done;
    logic [HASH_W-1:0]     mm_op_a_a, mm_op_b_a, mm_op_c_a, mm_res_a;
    logic [HASH_W-1:0]     mm_op_a_b, mm_op_b_b, mm_op_c_b, mm_res_b;

    assign pre_a_val = pre_zero_reg ? '0 : pre_a_q;
    assign pre_b_val = pre_zero_reg ? '0 : pre_b_q;
    assign mm_done   = mm_done_a && mm_done_b;

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        pv_next     = pv_reg;
        d_next      = d_reg;
        last_a_next = last_a_reg;
        last_b_next = last_b_reg;
        p_a_next    = p_a_reg;
        p_b_next    = p_b_reg;
        hl_a_next   = hl_a_reg;
        hl_b_next   = hl_b_reg;
        done_next   = 1'b0;
        hash_a_next = hash_a_reg;
        hash_b_next = hash_b_reg;
        length_next = length_reg;
        error_next  = error_reg;
        q_pop       = 1'b0;
        pre_rd_en   = 1'b0;
        pre_rd_addr = '0;
        pre_wr_en   = 1'b0;
        pre_wr_addr = len_reg + LEN_W'(1);
        pow_rd_en   = 1'b0;
        pow_rd_addr = d_reg;
        pow_wr_en   = 1'b0;
        pow_wr_addr = pv_reg;
        pow_wr_a    = mm_res_a;
        pow_wr_b    = mm_res_b;
        mm_start    = 1'b0;
        mm_op_a_a   = last_a_reg;
        mm_op_b_a   = cfg_base;
        mm_op_c_a   = '0;
        mm_op_a_b   = last_b_reg;
        mm_op_b_b   = cfg_base;
        mm_op_c_b   = '0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = BK_CHECK;
                end
            end
            BK_CHECK:
            begin
                unique case (cmd_reg.kind) inside
                    KIND_APPEND:
                    begin
                        if (len_reg >= LEN_W'(MAX_LEN))
                        begin
                            done_next   = 1'b1;
                            hash_a_next = '0;
                            hash_b_next = '0;
                            length_next = '0;
                            error_next  = 1'b1;
                            state_next  = BK_IDLE;
                        end
                        else
                        begin
                            pre_rd_en   = 1'b1;
                            pre_rd_addr = len_reg;
                            state_next  = BK_APP_RD;
                        end
                    end
                    KIND_QUERY, KIND_CONCAT:
                    begin
                        if (cmd_reg.static_err ||
                            (cmd_reg.kind == KIND_QUERY && cmd_reg.right > len_reg))
                        begin
                            done_next   = 1'b1;
                            hash_a_next = '0;
                            hash_b_next = '0;
                            length_next = '0;
                            error_next  = 1'b1;
                            state_next  = BK_IDLE;
                        end
                        else
                        begin
                            d_next     = (cmd_reg.kind == KIND_QUERY) ?
                                         cmd_reg.right - cmd_reg.left : cmd_reg.second_len;
                            state_next = BK_EXTEND;
                        end
                    end
                    default:
                    begin
                        len_next    = '0;
                        done_next   = 1'b1;
                        hash_a_next = '0;
                        hash_b_next = '0;
                        length_next = '0;
                        error_next  = 1'b0;
                        state_next  = BK_IDLE;
                    end
                endcase
            end
            BK_EXTEND:
            begin
                if (pv_reg <= d_reg)
                begin
                    if (pv_reg == '0)
                    begin
                        pow_wr_en   = 1'b1;
                        pow_wr_a    = HASH_W'(1);
                        pow_wr_b    = HASH_W'(1);
                        last_a_next = HASH_W'(1);
                        last_b_next = HASH_W'(1);
                        pv_next     = LEN_W'(1);
                    end
                    else
                    begin
                        mm_start   = 1'b1;
                        state_next = BK_EXT_WAIT;
                    end
                end
                else
                begin
                    pow_rd_en = 1'b1;
                    if (cmd_reg.kind == KIND_QUERY)
                    begin
                        pre_rd_en   = 1'b1;
                        pre_rd_addr = cmd_reg.left;
                        state_next  = BK_Q_RD1;
                    end
                    else
                    begin
                        state_next = BK_C_RD;
                    end
                end
            end
            BK_EXT_WAIT:
            begin
                if (mm_done)
                begin
                    pow_wr_en   = 1'b1;
                    last_a_next = mm_res_a;
                    last_b_next = mm_res_b;
                    pv_next     = pv_reg + LEN_W'(1);
                    state_next  = BK_EXTEND;
                end
            end
            BK_Q_RD1:
            begin
                p_a_next    = pow_a_q;
                p_b_next    = pow_b_q;
                hl_a_next   = pre_a_val;
                hl_b_next   = pre_b_val;
                pre_rd_en   = 1'b1;
                pre_rd_addr = cmd_reg.right;
                state_next  = BK_Q_RD2;
            end
            BK_Q_RD2:
            begin
                mm_start   = 1'b1;
                mm_op_a_a  = hl_a_reg;
                mm_op_b_a  = mod_a_eff - p_a_reg;
                mm_op_c_a  = pre_a_val;
                mm_op_a_b  = hl_b_reg;
                mm_op_b_b  = mod_b_eff - p_b_reg;
                mm_op_c_b  = pre_b_val;
                state_next = BK_CALC;
            end
            BK_C_RD:
            begin
                mm_start   = 1'b1;
                mm_op_a_a  = cmd_reg.first_hash_a;
                mm_op_b_a  = pow_a_q;
                mm_op_c_a  = cmd_reg.second_hash_a;
                mm_op_a_b  = cmd_reg.first_hash_b;
                mm_op_b_b  = pow_b_q;
                mm_op_c_b  = cmd_reg.second_hash_b;
                state_next = BK_CALC;
            end
            BK_APP_RD:
            begin
                mm_start   = 1'b1;
                mm_op_a_a  = pre_a_val;
                mm_op_c_a  = HASH_W'(cmd_reg.symbol);
                mm_op_a_b  = pre_b_val;
                mm_op_c_b  = HASH_W'(cmd_reg.symbol);
                state_next = BK_CALC;
            end
            BK_CALC:
            begin
                if (mm_done)
                begin
                    done_next   = 1'b1;
                    hash_a_next = mm_res_a;
                    hash_b_next = mm_res_b;
                    error_next  = 1'b0;
                    state_next  = BK_IDLE;
                    unique case (cmd_reg.kind)
                        KIND_APPEND:
                        begin
                            pre_wr_en   = 1'b1;
                            len_next    = len_reg + LEN_W'(1);
                            length_next = {1'b0, len_reg} + OUT_LEN_W'(1);
                        end
                        KIND_QUERY:
                        begin
                            length_next = {1'b0, d_reg};
                        end
                        default:
                        begin
                            length_next = {1'b0, cmd_reg.first_len} +
                                          {1'b0, cmd_reg.second_len};
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        if (powers_clear)
        begin
            pv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            len_reg   <= '0;
            pv_reg    <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
            pv_reg    <= pv_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        d_reg        <= d_next;
        last_a_reg   <= last_a_next;
        last_b_reg   <= last_b_next;
        p_a_reg      <= p_a_next;
        p_b_reg      <= p_b_next;
        hl_a_reg     <= hl_a_next;
        hl_b_reg     <= hl_b_next;
        pre_zero_reg <= (pre_rd_addr == '0);
        hash_a_reg   <= hash_a_next;
        hash_b_reg   <= hash_b_next;
        length_reg   <= length_next;
        error_reg    <= error_next;
    end

    dmrh_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_prefix_a (
        .clk     (clk),
        .wr_en   (pre_wr_en),
        .wr_addr (pre_wr_addr),
        .wr_data (mm_res_a),
        .rd_en   (pre_rd_en),
        .rd_addr (pre_rd_addr),
        .rd_data (pre_a_q)
    );

    dmrh_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_prefix_b (
        .clk     (clk),
        .wr_en   (pre_wr_en),
        .wr_addr (pre_wr_addr),
        .wr_data (mm_res_b),
        .rd_en   (pre_rd_en),
        .rd_addr (pre_rd_addr),
        .rd_data (pre_b_q)
    );

    dmrh_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_power_a (
        .clk     (clk),
        .wr_en   (pow_wr_en),
        .wr_addr (pow_wr_addr),
        .wr_data (pow_wr_a),
        .rd_en   (pow_rd_en),
        .rd_addr (pow_rd_addr),
        .rd_data (pow_a_q)
    );

    dmrh_ram #(.WIDTH(HASH_W), .DEPTH(TBL_DEPTH)) u_power_b (
        .clk     (clk),
        .wr_en   (pow_wr_en),
        .wr_addr (pow_wr_addr),
        .wr_data (pow_wr_b),
        .rd_en   (pow_rd_en),
        .rd_addr (pow_rd_addr),
        .rd_data (pow_b_q)
    );

    dmrh_mulmod u_mulmod_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_op_a_a),
        .op_b    (mm_op_b_a),
        .op_c    (mm_op_c_a),
        .modulus (mod_a_eff),
        .done    (mm_done_a),
        .result  (mm_res_a)
    );

    dmrh_mulmod u_mulmod_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .op_a    (mm_op_a_b),
        .op_b    (mm_op_b_b),
        .op_c    (mm_op_c_b),
        .modulus (mod_b_eff),
        .done    (mm_done_b),
        .result  (mm_res_b)
    );

    assign done   = done_reg;
    assign hash_a = hash_a_reg;
    assign hash_b = hash_b_reg;
    assign length = length_reg;
    assign error  = error_reg;

endmodule

@@ tb/dual_modulus_rolling_hash_tb.sv @@
// ----------------------------------------------------------------------------
// Dual modulus rolling hash testbench
// Drives append, substring query, concatenation and clear commands through
// the start/busy port and checks every result word against a predictor of
// the hash state. The run covers directed corner cases, a full string and
// random traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module dual_modulus_rolling_hash_tb
    import dmrh_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        kind_t             kind;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  left;
        logic [LEN_W-1:0]  right;
        logic [HASH_W-1:0] fha;
        logic [HASH_W-1:0] fhb;
        logic [LEN_W-1:0]  flen;
        logic [HASH_W-1:0] sha;
        logic [HASH_W-1:0] shb;
        logic [LEN_W-1:0]  slen;
    } cmd_word_t;

    typedef struct {
        logic [HASH_W-1:0]    ha;
        logic [HASH_W-1:0]    hb;
        logic [OUT_LEN_W-1:0] len;
        logic                 err;
    } hash_word_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [1:0]           kind = '0;
    logic [SYM_W-1:0]     symbol = '0;
    logic [LEN_W-1:0]     left = '0;
    logic [LEN_W-1:0]     right = '0;
    logic [HASH_W-1:0]    first_hash_a = '0;
    logic [HASH_W-1:0]    first_hash_b = '0;
    logic [LEN_W-1:0]     first_len = '0;
    logic [HASH_W-1:0]    second_hash_a = '0;
    logic [HASH_W-1:0]    second_hash_b = '0;
    logic [LEN_W-1:0]     second_len = '0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [HASH_W-1:0]    cfg_data = '0;
    logic                 done;
    logic [HASH_W-1:0]    hash_a;
    logic [HASH_W-1:0]    hash_b;
    logic [OUT_LEN_W-1:0] length;
    logic                 error;

    cmd_word_t  pending_cmds[$];
    hash_word_t expected_hashes[$];
    cmd_word_t  cur_cmd;
    int         fail_count = 0;
    int         send_idle_pct = 0;
    longint     cycle_count = 0;
    int         plan_len = 0;

    logic [HASH_W-1:0] mod_a_reg, mod_b_reg, base_reg;
    logic [HASH_W-1:0] pre_a[0:MAX_LEN];
    logic [HASH_W-1:0] pre_b[0:MAX_LEN];
    logic [HASH_W-1:0] pow_a[0:MAX_LEN];
    logic [HASH_W-1:0] pow_b[0:MAX_LEN];
    int                str_len;
    int                pow_count;

    dual_modulus_rolling_hash uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .symbol(symbol), .left(left), .right(right),
        .first_hash_a(first_hash_a), .first_hash_b(first_hash_b),
        .first_len(first_len), .second_hash_a(second_hash_a),
        .second_hash_b(second_hash_b), .second_len(second_len),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .hash_a(hash_a), .hash_b(hash_b), .length(length),
        .error(error)
    );

    always #2 clk = ~clk;

    function automatic longint unsigned modulus_of(input logic [HASH_W-1:0] m);
        return (m < 2) ? 64'd2 : 64'(m);
    endfunction

    task automatic grow_powers(input int n);
        longint unsigned ma, mb;
        ma = modulus_of(mod_a_reg);
        mb = modulus_of(mod_b_reg);
        while (pow_count <= n) begin
            if (pow_count == 0) begin
                pow_a[0] = 1;
                pow_b[0] = 1;
            end
            else begin
                pow_a[pow_count] = HASH_W'((64'(pow_a[pow_count-1]) * base_reg) % ma);
                pow_b[pow_count] = HASH_W'((64'(pow_b[pow_count-1]) * base_reg) % mb);
            end
            pow_count++;
        end
    endtask

    task automatic predict_hash(input cmd_word_t c);
        hash_word_t      r;
        longint unsigned ma, mb, x, s;
        int              d;
        ma = modulus_of(mod_a_reg);
        mb = modulus_of(mod_b_reg);
        r = '{default: '0};
        case (c.kind)
            KIND_APPEND: begin
                if (str_len >= MAX_LEN) begin
                    r.err = 1'b1;
                end
                else begin
                    r.ha = HASH_W'(((64'(pre_a[str_len]) % ma) * base_reg + c.symbol) % ma);
                    r.hb = HASH_W'(((64'(pre_b[str_len]) % mb) * base_reg + c.symbol) % mb);
                    pre_a[str_len+1] = r.ha;
                    pre_b[str_len+1] = r.hb;
                    str_len++;
                    r.len = OUT_LEN_W'(str_len);
                end
            end
            KIND_QUERY: begin
                if (c.left > c.right || c.right > str_len || c.right > MAX_LEN) begin
                    r.err = 1'b1;
                end
                else begin
                    d = c.right - c.left;
                    grow_powers(d);
                    x = (64'(pre_a[c.left]) * pow_a[d]) % ma;
                    r.ha = HASH_W'((64'(pre_a[c.right]) % ma + ma - x) % ma);
                    x = (64'(pre_b[c.left]) * pow_b[d]) % mb;
                    r.hb = HASH_W'((64'(pre_b[c.right]) % mb + mb - x) % mb);
                    r.len = OUT_LEN_W'(d);
                end
            end
            KIND_CONCAT: begin
                if (c.flen > MAX_LEN || c.slen > MAX_LEN) begin
                    r.err = 1'b1;
                end
                else begin
                    grow_powers(c.slen);
                    s = (64'(c.fha) * pow_a[c.slen]) % ma + 64'(c.sha) % ma;
                    if (s >= ma) s -= ma;
                    r.ha = HASH_W'(s);
                    s = (64'(c.fhb) * pow_b[c.slen]) % mb + 64'(c.shb) % mb;
                    if (s >= mb) s -= mb;
                    r.hb = HASH_W'(s);
                    r.len = OUT_LEN_W'(c.flen) + OUT_LEN_W'(c.slen);
                end
            end
            default: begin
                str_len = 0;
            end
        endcase
        expected_hashes.insert(expected_hashes.size(), r);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            if (start && !busy) predict_hash(cur_cmd);
            if (start && busy) begin
                start <= 1'b1;
            end
            else if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cur_cmd = pending_cmds.pop_front();
                start <= 1'b1;
                kind <= cur_cmd.kind;
                symbol <= cur_cmd.symbol;
                left <= cur_cmd.left;
                right <= cur_cmd.right;
                first_hash_a <= cur_cmd.fha;
                first_hash_b <= cur_cmd.fhb;
                first_len <= cur_cmd.flen;
                second_hash_a <= cur_cmd.sha;
                second_hash_b <= cur_cmd.shb;
                second_len <= cur_cmd.slen;
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        hash_word_t e;
        if (rst_n && done) begin
            if (expected_hashes.size() == 0) begin
                $display("%0t: unexpected result word hash_a=%0d hash_b=%0d length=%0d",
                         $time, hash_a, hash_b, length);
                fail_count++;
            end
            else begin
                e = expected_hashes.pop_front();
                if (hash_a !== e.ha) begin
                    $display("%0t: hash_a expected %0d actual %0d", $time, e.ha, hash_a);
                    fail_count++;
                end
                if (hash_b !== e.hb) begin
                    $display("%0t: hash_b expected %0d actual %0d", $time, e.hb, hash_b);
                    fail_count++;
                end
                if (length !== e.len) begin
                    $display("%0t: length expected %0d actual %0d", $time, e.len, length);
                    fail_count++;
                end
                if (error !== e.err) begin
                    $display("%0t: error expected %0d actual %0d", $time, e.err, error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("dual_modulus_rolling_hash regression: fail");
            $finish;
        end
    end

    function automatic logic [HASH_W-1:0] rand_hash();
        case ($urandom_range(9))
            0: return '1;
            1: return '0;
            default: return HASH_W'($urandom());
        endcase
    endfunction

    task automatic queue_cmd(input kind_t k, input int sym, input int l, input int r,
                             input logic [HASH_W-1:0] fa, input logic [HASH_W-1:0] fb,
                             input int fl, input logic [HASH_W-1:0] sa,
                             input logic [HASH_W-1:0] sb, input int sl);
        cmd_word_t c;
        c.kind = k;
        c.symbol = SYM_W'(sym);
        c.left = LEN_W'(l);
        c.right = LEN_W'(r);
        c.fha = fa;
        c.fhb = fb;
        c.flen = LEN_W'(fl);
        c.sha = sa;
        c.shb = sb;
        c.slen = LEN_W'(sl);
        if (k == KIND_APPEND && plan_len < MAX_LEN) plan_len++;
        if (k == KIND_CLEAR) plan_len = 0;
        pending_cmds.insert(pending_cmds.size(), c);
    endtask

    task automatic queue_random_cmd();
        int sel, l, r, sl;
        sel = $urandom_range(99);
        if (sel < 40) begin
            queue_cmd(KIND_APPEND, $urandom_range(255), $urandom_range(2047),
                      $urandom_range(2047), rand_hash(), rand_hash(),
                      $urandom_range(2047), rand_hash(), rand_hash(), $urandom_range(2047));
        end
        else if (sel < 70) begin
            if ($urandom_range(9) < 8) begin
                r = $urandom_range(plan_len);
                l = $urandom_range(r);
            end
            else begin
                r = $urandom_range(2047);
                l = $urandom_range(2047);
            end
            queue_cmd(KIND_QUERY, $urandom_range(255), l, r, rand_hash(), rand_hash(),
                      $urandom_range(2047), rand_hash(), rand_hash(), $urandom_range(2047));
        end
        else if (sel < 92) begin
            sel = $urandom_range(99);
            if (sel < 90) sl = $urandom_range(64);
            else if (sel < 97) sl = $urandom_range(MAX_LEN);
            else sl = $urandom_range(2047, MAX_LEN + 1);
            queue_cmd(KIND_CONCAT, $urandom_range(255), $urandom_range(2047),
                      $urandom_range(2047), rand_hash(), rand_hash(),
                      ($urandom_range(19) == 0) ? $urandom_range(2047) : $urandom_range(MAX_LEN),
                      rand_hash(), rand_hash(), sl);
        end
        else begin
            queue_cmd(KIND_CLEAR, $urandom_range(255), $urandom_range(2047),
                      $urandom_range(2047), rand_hash(), rand_hash(),
                      $urandom_range(2047), rand_hash(), rand_hash(), $urandom_range(2047));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_cmds.size() > 0 || start || expected_hashes.size() > 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HASH_W-1:0] v);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        case (idx)
            CFG_BASE:  base_reg = v;
            CFG_MOD_A: mod_a_reg = v;
            CFG_MOD_B: mod_b_reg = v;
            default:   ;
        endcase
        if (idx == CFG_BASE || idx == CFG_MOD_A || idx == CFG_MOD_B) pow_count = 0;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_phase(input int n, input int idle_pct);
        send_idle_pct = idle_pct;
        repeat (n) queue_random_cmd();
        drain();
    endtask

    initial begin
        base_reg = 1007;
        mod_a_reg = 1000000007;
        mod_b_reg = 998244353;
        str_len = 0;
        pow_count = 0;
        pre_a[0] = '0;
        pre_b[0] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Corner cases under the reset settings.
        queue_cmd(KIND_QUERY, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_APPEND, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_APPEND, 255, 2047, 2047, '1, '1, 2047, '1, '1, 2047);
        queue_cmd(KIND_APPEND, 170, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, 3, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 1, 3, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 2, 2, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 3, 2, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, 4, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 2047, 2047, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_CONCAT, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_CONCAT, 0, 0, 0, '1, '1, 0, '1, '1, 0);
        queue_cmd(KIND_CONCAT, 0, 0, 0, '1, '1, MAX_LEN, '1, '1, MAX_LEN);
        queue_cmd(KIND_CONCAT, 0, 0, 0, 5, 6, MAX_LEN + 1, 7, 8, 3);
        queue_cmd(KIND_CONCAT, 0, 0, 0, 5, 6, 3, 7, 8, 2047);
        queue_cmd(KIND_CONCAT, 0, 0, 0, 1000000007, 998244353, 1, 1000000008, 998244354, 1);
        queue_cmd(KIND_CLEAR, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, 1, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_APPEND, 1, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, 1, '0, '0, 0, '0, '0, 0);
        drain();

        // Fill the string to its limit, then overflow it.
        queue_cmd(KIND_CLEAR, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        repeat (MAX_LEN) queue_cmd(KIND_APPEND, $urandom_range(255), 0, 0, '0, '0, 0,
                                   '0, '0, 0);
        queue_cmd(KIND_APPEND, 9, 0, 0, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 0, MAX_LEN, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, MAX_LEN - 1, MAX_LEN, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_QUERY, 0, 512, MAX_LEN + 1, '0, '0, 0, '0, '0, 0);
        queue_cmd(KIND_CLEAR, 0, 0, 0, '0, '0, 0, '0, '0, 0);
        drain();

        random_phase(20, 0);

        write_reg(CFG_BASE, 2);
        write_reg(CFG_MOD_A, 31'h7FFFFFFF);
        write_reg(CFG_MOD_B, 2);
        random_phase(15, 87);

        write_reg(CFG_BASE, 31'h7FFFFFFE);
        write_reg(CFG_MOD_A, 0);
        write_reg(CFG_MOD_B, 1);
        write_reg(CFG_UNUSED, 31'h12345);
        random_phase(10, 23);

        write_reg(CFG_BASE, HASH_W'($urandom()));
        write_reg(CFG_MOD_A, HASH_W'($urandom_range(32'h7FFFFFFF, 2)));
        write_reg(CFG_MOD_B, HASH_W'($urandom_range(1000, 2)));
        random_phase(5, 0);
        random_phase(5, 87);
        random_phase(5, 0);

        repeat (100) @(posedge clk);
        if (fail_count == 0 && expected_hashes.size() == 0) begin
            $display("dual_modulus_rolling_hash regression: pass");
        end
        else begin
            $display("dual_modulus_rolling_hash regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/dmrh_pkg.sv
rtl/dmrh_ram.sv
rtl/dmrh_front.sv
rtl/dmrh_mulmod.sv
rtl/dmrh_back.sv
rtl/dual_modulus_rolling_hash.sv
tb/dual_modulus_rolling_hash_tb.sv
